@@ src/dsp_pkg.sv @@
// Shared types and constants for the shortest-path engine.
package dsp_pkg;
    localparam int MaxVertices = 64;
    localparam int MaxEdges    = 256;
    localparam int WeightBits  = 16;
    localparam int VBits       = 6;
    localparam int EBits       = 8;
    localparam int DistBits    = 24;
    localparam int VtxBits     = DistBits + VBits + 2;   // {reached, visited, dist, pred}
    localparam int EdgeBits    = 2*VBits + WeightBits;   // {tail, head, weight}
    localparam logic [DistBits-1:0] DistMax = '1;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_STORED = 3'd0,
        ST_FULL   = 3'd1,
        ST_PATH   = 3'd2,
        ST_NOPATH = 3'd3,
        ST_BADV   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_OUT, S_INIT, S_SCAN, S_SCAN_END, S_EDGE, S_EREAD, S_RELAX,
        S_TRACE, S_TWAIT, S_PREAD, S_EMIT
    } t_state;
endpackage

@@ src/dsp_vtx_mem.sv @@
// Per-vertex scratch memory: {reached, visited, distance, predecessor}.
module dsp_vtx_mem
    import dsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [VBits-1:0]    i_waddr,
    input  logic [DistBits+VBits+1:0] i_wdata,
    input  logic [VBits-1:0]    i_raddr,
    output logic [DistBits+VBits+1:0] o_rdata
);
    logic [DistBits+VBits+1:0] r_mem [MaxVertices];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/dsp_edge_mem.sv @@
// Edge table memory: {tail, head, weight}.
module dsp_edge_mem
    import dsp_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [EBits-1:0]              i_waddr,
    input  logic [2*VBits+WeightBits-1:0] i_wdata,
    input  logic [EBits-1:0]              i_raddr,
    output logic [2*VBits+WeightBits-1:0] o_rdata
);
    logic [2*VBits+WeightBits-1:0] r_mem [MaxEdges];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/dijkstra_shortest_path.sv @@
// Top level of the shortest-path engine: control sequencer and stream ports.
// One transaction is handled at a time. An add-edge or a bad-vertex transaction
// gives its single result via the S_OUT state (decode, then result register).
// A query first initializes the vertex scratch memory. Each round then scans
// all nv vertices through the one read port of the vertex memory for the
// closest unsettled one and, unless that vertex is the destination, walks the
// whole edge table, each stored edge going through edge read, head read and
// head write. The path is traced back into a path buffer and emitted source
// first when the output is ready. A result waits in the output register; the
// next input is taken only after the last result has left.
module dijkstra_shortest_path
    import dsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,      // vertex_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,     // from[5:0], to[11:6], weight[27:12]
    input  logic        s_axis_tuser,     // opcode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,     // path_vertex[5:0]
    output logic [2:0]  m_axis_tuser,     // status[2:0]
    output logic        m_axis_tlast
);
    t_state r_state, n_state;
    logic [6:0]            r_vcount;
    logic [EBits:0]        r_etotal;
    logic                  r_op;
    logic [VBits-1:0]      r_src, r_dst;
    logic [WeightBits-1:0] r_w;
    logic [6:0]            r_nv;
    logic [6:0]            r_i;            // init / scan index
    logic [EBits:0]        r_e;
    logic                  r_bfound;
    logic [VBits-1:0]      r_best, r_bpred;
    logic [DistBits-1:0]   r_bdist;
    logic [VBits-1:0]      r_u;
    logic [DistBits-1:0]   r_udist;
    logic [VBits-1:0]      r_cur;
    logic [VBits:0]        r_plen;
    logic [VBits-1:0]      r_path [MaxVertices];
    logic [VBits-1:0]      r_pq;
    logic                  r_ovalid;
    t_status               r_ostat;
    logic [VBits-1:0]      r_overt;
    logic                  r_olast;
    logic [EdgeBits-1:0]   r_edge_hold;

    logic                  vm_we;
    logic [VBits-1:0]      vm_waddr, vm_raddr;
    logic [VtxBits-1:0]    vm_wdata, vm_rdata;
    logic                  em_we;
    logic [EBits-1:0]      em_raddr;
    logic [EdgeBits-1:0]   em_rdata;
    logic [VBits-1:0]      em_head;

    logic                  rd_reached, rd_visited;
    logic [DistBits-1:0]   rd_dist;
    logic [VBits-1:0]      rd_pred;

    logic                  in_fire, out_fire, out_free;
    logic [6:0]            live_nv;
    logic [VBits-1:0]      in_from, in_to;
    logic                  in_bad, out_bad, etable_full;

    logic [VBits-1:0]      e_tail, e_head;
    logic [WeightBits-1:0] e_w;
    logic [DistBits:0]     nd_sum;
    logic [DistBits-1:0]   nd;
    logic                  edge_ok, relax_win;
    logic [VBits-1:0]      scan_idx;
    logic                  scan_win;
    logic [VBits-1:0]      p_raddr;

    dsp_vtx_mem u_vtx (.i_clk, .i_we(vm_we), .i_waddr(vm_waddr), .i_wdata(vm_wdata),
                       .i_raddr(vm_raddr), .o_rdata(vm_rdata));
    dsp_edge_mem u_edge (.i_clk, .i_we(em_we), .i_waddr(r_etotal[EBits-1:0]),
                         .i_wdata({r_src, r_dst, r_w}), .i_raddr(em_raddr),
                         .o_rdata(em_rdata));

    // vertex entry fields
    assign {rd_reached, rd_visited, rd_dist, rd_pred} = vm_rdata;
    assign em_head = em_rdata[WeightBits +: VBits];

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = r_ovalid && m_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_overt};
    assign m_axis_tuser  = r_ostat;
    assign m_axis_tlast  = r_olast;

    assign live_nv = (r_vcount > 7'(MaxVertices)) ? 7'(MaxVertices) : r_vcount;

    assign in_from = s_axis_tdata[5:0];
    assign in_to   = s_axis_tdata[11:6];
    assign in_bad  = ({1'b0, in_from} >= live_nv) || ({1'b0, in_to} >= live_nv);
    assign out_bad = ({1'b0, r_src} >= r_nv) || ({1'b0, r_dst} >= r_nv);
    assign etable_full = (r_etotal == (EBits+1)'(MaxEdges));

    // edge being relaxed (registered read data); sum saturates at DistMax
    assign {e_tail, e_head, e_w} = r_edge_hold;
    assign nd_sum = {1'b0, r_udist} + {{(DistBits+1-WeightBits){1'b0}}, e_w};
    assign nd = nd_sum[DistBits] ? DistMax : nd_sum[DistBits-1:0];
    assign edge_ok = (e_tail == r_u) && ({1'b0, e_head} < r_nv) &&
                     ({1'b0, e_tail} < r_nv);
    // only a strictly shorter distance moves the predecessor
    assign relax_win = edge_ok && !rd_visited && (!rd_reached || nd < rd_dist);

    // scan candidate: data now on vm_rdata belongs to index r_i-1;
    // strict compare in index order keeps the lowest vertex on ties
    assign scan_idx = r_i[VBits-1:0] - VBits'(1);
    assign scan_win = (r_i != 7'd0) && rd_reached && !rd_visited &&
                      (!r_bfound || rd_dist < r_bdist);

    // path buffer is read from the top down, source first
    assign p_raddr = r_plen[VBits-1:0] - VBits'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_fire) begin
                if (in_bad || s_axis_tuser == OP_ADD || in_from == in_to)
                    n_state = S_OUT;
                else
                    n_state = S_INIT;
            end
            S_OUT:      n_state = S_IDLE;
            S_INIT:     if (r_i == r_nv - 7'd1) n_state = S_SCAN;
            S_SCAN:     if (r_i == r_nv) n_state = S_SCAN_END;
            S_SCAN_END: begin
                if (!r_bfound) n_state = S_OUT;          // destination unreachable
                else if (r_best == r_dst) n_state = S_TRACE;
                else n_state = S_EDGE;
            end
            S_EDGE:     if (r_e == r_etotal) n_state = S_SCAN; else n_state = S_EREAD;
            S_EREAD:    n_state = S_RELAX;
            S_RELAX:    n_state = S_EDGE;
            S_TRACE:    if (r_cur == r_src) n_state = S_PREAD; else n_state = S_TWAIT;
            S_TWAIT:    n_state = S_TRACE;
            S_PREAD:    n_state = S_EMIT;
            S_EMIT:     if (out_free) begin
                if (r_plen == (VBits+1)'(1)) n_state = S_IDLE;
                else n_state = S_PREAD;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // memory control
    always_comb begin
        vm_we = 1'b0; vm_waddr = r_i[VBits-1:0]; vm_wdata = '0;
        vm_raddr = r_i[VBits-1:0];
        em_we = 1'b0; em_raddr = r_e[EBits-1:0];
        unique case (r_state)
            S_OUT: em_we = (r_op == OP_ADD) && !out_bad && !etable_full;
            S_INIT: begin
                vm_we = 1'b1;
                vm_wdata = (r_i[VBits-1:0] == r_src) ? {2'b10, {DistBits{1'b0}}, {VBits{1'b0}}}
                                                   : {2'b00, DistMax, {VBits{1'b0}}};
            end
            S_SCAN_END: begin
                // settle the chosen vertex, keeping its predecessor
                vm_we = r_bfound && r_best != r_dst;
                vm_waddr = r_best;
                vm_wdata = {2'b11, r_bdist, r_bpred};
            end
            S_EREAD: vm_raddr = em_head;
            S_RELAX: begin
                vm_waddr = e_head;
                vm_we = relax_win;
                vm_wdata = {2'b10, nd, r_u};
            end
            S_TRACE: vm_raddr = r_cur;
            default: ;
        endcase
    end

    // control, edge count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcount <= 7'(MaxVertices);
            r_etotal <= '0;
            r_ovalid <= 1'b0;
            r_ostat  <= ST_STORED;
            r_overt  <= '0;
            r_olast  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_vcount <= i_cfg_wdata;
            if (em_we) r_etotal <= r_etotal + 1'b1;
            if (r_state == S_OUT) begin
                r_ovalid <= 1'b1;
                r_olast  <= 1'b1;
                r_overt  <= (!out_bad && r_op == OP_QUERY && r_src == r_dst) ? r_src : '0;
                if (out_bad) r_ostat <= ST_BADV;
                else if (r_op == OP_QUERY) begin
                    if (r_src == r_dst) r_ostat <= ST_PATH;
                    else r_ostat <= ST_NOPATH;
                end else if (etable_full) r_ostat <= ST_FULL;
                else r_ostat <= ST_STORED;
            end else if (r_state == S_EMIT && out_free) begin
                r_ovalid <= 1'b1;
                r_ostat  <= ST_PATH;
                r_overt  <= r_pq;
                r_olast  <= (r_plen == (VBits+1)'(1));
            end else if (out_fire) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload / datapath registers and path buffer
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (in_fire) begin
                r_op <= s_axis_tuser;
                r_src <= in_from; r_dst <= in_to;
                r_w <= s_axis_tdata[27:12];
                r_nv <= live_nv;
                r_i <= '0;
                r_cur <= in_to;
                r_plen <= '0;
            end
            S_INIT: begin
                r_i <= (r_i == r_nv - 7'd1) ? 7'd0 : r_i + 7'd1;
                r_bfound <= 1'b0;
            end
            S_SCAN: begin
                r_i <= r_i + 7'd1;
                if (scan_win) begin
                    r_bfound <= 1'b1; r_best <= scan_idx;
                    r_bdist <= rd_dist; r_bpred <= rd_pred;
                end
            end
            S_SCAN_END: begin
                r_u <= r_best; r_udist <= r_bdist;
                r_e <= '0;
            end
            S_EDGE: if (r_e == r_etotal) begin
                r_i <= '0;
                r_bfound <= 1'b0;
            end
            S_EREAD: r_edge_hold <= em_rdata;
            S_RELAX: r_e <= r_e + 1'b1;
            S_TRACE: begin
                r_path[r_plen[VBits-1:0]] <= r_cur;
                r_plen <= r_plen + 1'b1;
            end
            S_TWAIT: r_cur <= rd_pred;
            S_EMIT: if (out_free) r_plen <= r_plen - 1'b1;
            default: ;
        endcase
        r_pq <= r_path[p_raddr];
    end

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tuser) && $stable(m_axis_tlast));
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid);
    a_etotal_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_etotal <= (EBits+1)'(MaxEdges));
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= ST_BADV);
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_PATH |-> m_axis_tlast);
endmodule
